// ----- rtl/prf_pkg.sv -----
// ---------------------------------------------------------------------------
// prf_pkg
// Shared constants and types for the FIFO/LRU page replacement unit.
// ---------------------------------------------------------------------------
package prf_pkg;

    // defaults for the top-level parameters
    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_WIDTH_DEF = 16;

    // fixed field widths of the stream words
    localparam int PAGE_FIELD_W  = 16;
    localparam int SLOT_FIELD_W  = 3;
    localparam int TOTAL_FIELD_W = 16;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 40;
    localparam int OUT_USED_W    = 1 + SLOT_FIELD_W + 1 + PAGE_FIELD_W + TOTAL_FIELD_W;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_USED_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FRAMES_IN_USE_RST = 4'd8;

    localparam logic [TOTAL_FIELD_W-1:0] FAULT_MAX = '1;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } t_policy;

    // one result word
    typedef struct packed {
        logic [TOTAL_FIELD_W-1:0] fault_total;
        logic [PAGE_FIELD_W-1:0]  evicted_page;
        logic                     evicted_valid;
        logic [SLOT_FIELD_W-1:0]  slot_index;
        logic                     page_fault;
    } t_result;

endpackage

// ----- rtl/page_replacement_fifo_lru.sv -----
// ---------------------------------------------------------------------------
// page_replacement_fifo_lru
// a page word is held in the input register, then its result word in the result register
// throughput: one page reference per cycle while the result stream does not stall,
//   with the frame compare and victim select combinational between the two registers
// reset: synchronous, clears all frames to empty, the fault count to zero,
//   and the configuration to all eight frames in FIFO mode
// ---------------------------------------------------------------------------
module page_replacement_fifo_lru #(
    parameter int MAX_FRAMES = prf_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_WIDTH = prf_pkg::PAGE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [prf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // page reference stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [prf_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [15:0] page_number
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] page_fault, [3:1] slot_index, [4] evicted_valid, [20:5] evicted_page,
    // [36:21] fault_total, [39:37] zero
    output logic [prf_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = ($clog2(MAX_FRAMES + 1) > prf_pkg::CFG_DATA_W) ?
                            $clog2(MAX_FRAMES + 1) : prf_pkg::CFG_DATA_W;

    // configuration
    logic [prf_pkg::CFG_DATA_W-1:0] r_frames_cfg;
    prf_pkg::t_policy               r_policy;

    // input stage
    logic                            r_in_valid;
    logic [prf_pkg::IN_DATA_W-1:0]   r_in_page;

    // frame state
    logic [PAGE_WIDTH-1:0] r_pages [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [SLOT_W-1:0]     r_rank  [MAX_FRAMES];
    logic [SLOT_W-1:0]     r_fifo_ptr;
    logic [CNT_W-1:0]      r_filled;
    logic [prf_pkg::TOTAL_FIELD_W-1:0] r_faults;

    // result stage
    logic             r_out_valid;
    prf_pkg::t_result r_out;

    logic w_adv;
    logic w_go;

    // combinational work on the word in the input stage
    logic [PAGE_WIDTH-1:0]             w_page;
    logic [CNT_W-1:0]                  w_eff;
    logic                              w_hit;
    logic [SLOT_W-1:0]                 w_hit_slot;
    logic [SLOT_W-1:0]                 w_lru_slot;
    logic [SLOT_W-1:0]                 w_slot;
    logic                              w_fill;
    logic                              w_replace;
    logic [SLOT_W-1:0]                 w_old_rank;
    logic [CNT_W-1:0]                  w_slot_next;
    logic [SLOT_W-1:0]                 n_rank [MAX_FRAMES];
    logic [prf_pkg::TOTAL_FIELD_W-1:0] n_faults;
    prf_pkg::t_result                  n_out;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_go          = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{prf_pkg::OUT_PAD_W{1'b0}}, r_out};

    always_comb begin
        w_page = PAGE_WIDTH'(r_in_page);

        // zero acts as one, oversize acts as the full set
        if (r_frames_cfg == '0) begin
            w_eff = CNT_W'(1);
        end else if (CNT_W'(r_frames_cfg) > CNT_W'(MAX_FRAMES)) begin
            w_eff = CNT_W'(MAX_FRAMES);
        end else begin
            w_eff = CNT_W'(r_frames_cfg);
        end

        // lowest matching frame in use wins
        w_hit      = 1'b0;
        w_hit_slot = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
            if (CNT_W'(k) < w_eff && r_valid[k] && r_pages[k] == w_page) begin
                w_hit      = 1'b1;
                w_hit_slot = SLOT_W'(k);
            end
        end

        // oldest rank among frames in use, first one on a tie
        w_lru_slot = '0;
        for (int k = 1; k < MAX_FRAMES; k++) begin
            if (CNT_W'(k) < w_eff && r_rank[k] > r_rank[w_lru_slot]) begin
                w_lru_slot = SLOT_W'(k);
            end
        end

        w_fill = !w_hit && (r_filled < w_eff);
        priority if (w_hit) begin
            w_slot = w_hit_slot;
        end else if (w_fill) begin
            w_slot = SLOT_W'(r_filled);
        end else if (r_policy == prf_pkg::POLICY_FIFO) begin
            w_slot = (CNT_W'(r_fifo_ptr) < w_eff) ? r_fifo_ptr : '0;
        end else begin
            w_slot = w_lru_slot;
        end

        w_replace  = !w_hit && r_valid[w_slot];
        w_old_rank = r_rank[w_slot];

        // touched frame becomes youngest, the younger ones age by one (every valid one on a fill)
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (SLOT_W'(k) == w_slot) begin
                n_rank[k] = '0;
            end else if (r_valid[k] && (w_fill || r_rank[k] < w_old_rank)) begin
                n_rank[k] = r_rank[k] + 1'b1;
            end else begin
                n_rank[k] = r_rank[k];
            end
        end

        w_slot_next = CNT_W'(w_slot) + 1'b1;
        if (w_slot_next == w_eff) begin
            w_slot_next = '0;
        end

        if (!w_hit && r_faults != prf_pkg::FAULT_MAX) begin
            n_faults = r_faults + 1'b1;
        end else begin
            n_faults = r_faults;
        end

        n_out.page_fault    = !w_hit;
        n_out.slot_index    = prf_pkg::SLOT_FIELD_W'(w_slot);
        n_out.evicted_valid = w_replace;
        n_out.evicted_page  = w_replace ? prf_pkg::PAGE_FIELD_W'(r_pages[w_slot]) : '0;
        n_out.fault_total   = n_faults;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= prf_pkg::FRAMES_IN_USE_RST;
            r_policy     <= prf_pkg::POLICY_FIFO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prf_pkg::CFG_FRAMES_IN_USE: r_frames_cfg <= i_cfg_data;
                prf_pkg::CFG_POLICY_MODE:   r_policy     <= prf_pkg::t_policy'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_page <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fifo_ptr <= '0;
            r_filled   <= '0;
            r_faults   <= '0;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_rank[k] <= '0;
            end
        end else if (w_go) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_rank[k] <= n_rank[k];
            end
            r_faults <= n_faults;
            if (!w_hit) begin
                r_valid[w_slot] <= 1'b1;
                r_fifo_ptr      <= SLOT_W'(w_slot_next);
            end
            if (w_fill) begin
                r_filled <= r_filled + 1'b1;
            end
        end
    end

    // page store, only read where the valid bit is set
    always_ff @(posedge i_clk) begin
        if (w_go && !w_hit) begin
            r_pages[w_slot] <= w_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/prf_checker.sv -----
// ---------------------------------------------------------------------------
// prf_checker
// Port-level checks on the page replacement unit, bound to the top level.
// ---------------------------------------------------------------------------
module prf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [prf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    prf_pkg::t_result w_res;

    assign w_res = prf_pkg::t_result'(m_axis_tdata[prf_pkg::OUT_USED_W-1:0]);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_res.page_fault |->
            !w_res.evicted_valid && w_res.evicted_page == '0)
        else $error("eviction reported on a hit");

    // a fault has been counted
    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.page_fault |-> w_res.fault_total != '0)
        else $error("fault word with zero fault count");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[prf_pkg::OUT_DATA_W-1:prf_pkg::OUT_USED_W] == '0)
        else $error("result padding not zero");

endmodule

bind page_replacement_fifo_lru prf_checker u_prf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
